FILE: hdl/fhtd_pkg.sv
// Package for the fhan tracking differentiator: fixed-point constants,
// request/result/config structs, datapath ops and controller states.
// No dependencies.
package fhtd_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [63:0] PI_Q32     = 64'h0000_0003_243F_6A88;
  localparam logic [63:0] TWO_PI_Q32 = 64'h0000_0006_487E_D511;

  // pi and 2*pi rounded to FRAC_BITS fractional bits
  localparam logic signed [35:0] PI_Q =
    36'((PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam logic signed [35:0] TAU_Q =
    36'((TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

  // reciprocal of 2*pi for the wrap quotient; the estimate is low by at most one
  localparam int          TAU_RCP_SH = 50;
  localparam logic [31:0] TAU_RCP    = 32'((64'd1 << TAU_RCP_SH) / 64'(TAU_Q));

  localparam logic [1:0] REG_TRACK_SPEED   = 2'd0;
  localparam logic [1:0] REG_STEP_TIME     = 2'd1;
  localparam logic [1:0] REG_FILTER_FACTOR = 2'd2;
  localparam logic [1:0] REG_ANGLE_MODE    = 2'd3;

  typedef struct packed {
    logic [31:0] track_speed;
    logic [23:0] step_time;
    logic [15:0] filter_factor;
    logic        angle_mode;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] target_value;
    logic signed [31:0] position_value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] rate_estimate;
    logic signed [31:0] tracked_position;
    logic signed [31:0] accel_command;
    logic               saturated;
  } out_res_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_CAPTURE, OP_LOAD, OP_ERR,
    OP_MUL_H0, OP_RND_H0, OP_MUL_H2, OP_RND_H2, OP_MUL_WIN, OP_RND_WIN,
    OP_ACC_ZERO, OP_MUL_PRE, OP_RND_PRE, OP_LEAD, OP_INNER, OP_MUL_RAD,
    OP_SQ_INIT, OP_SQ_STEP, OP_CURVE, OP_BLEND, OP_MUL_P, OP_DIV_INIT,
    OP_DIV_STEP, OP_ACC_Q, OP_ACC_R, OP_MUL_DX, OP_RND_DX, OP_MUL_X,
    OP_RND_X, OP_WR_INIT, OP_WR_RCP, OP_WR_MUL, OP_WR_APPLY, OP_POS, OP_EMIT
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_SORT, S_LOAD, S_ERR,
    S_MUL_H0, S_RND_H0, S_MUL_H2, S_RND_H2, S_MUL_WIN, S_RND_WIN,
    S_ACC_ZERO, S_MUL_PRE, S_RND_PRE, S_LEAD, S_INNER, S_MUL_RAD,
    S_SQ_INIT, S_SQ_RUN, S_CURVE, S_BLEND, S_MUL_P, S_DIV_INIT,
    S_DIV_RUN, S_ACC_Q, S_ACC_R, S_MUL_DX, S_RND_DX, S_MUL_X,
    S_RND_X, S_WR_INIT, S_WR_RCP, S_WR_MUL, S_WR_APPLY, S_POS, S_EMIT
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic win_zero;
    logic blend_lt_win;
    logic sq_last;
    logic div_last;
    logic out_busy;
    logic angle;
  } dp_status_t;

endpackage

FILE: hdl/fhtd_ctrl.sv
// Controller state machine of the fhan tracking differentiator.
// Sequences datapath ops; depends on fhtd_pkg.
module fhtd_ctrl import fhtd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_SORT;
      S_SORT:     state_next = status.is_load ? S_LOAD : S_ERR;
      S_LOAD:     state_next = S_EMIT;
      S_ERR:      state_next = S_MUL_H0;
      S_MUL_H0:   state_next = S_RND_H0;
      S_RND_H0:   state_next = S_MUL_H2;
      S_MUL_H2:   state_next = S_RND_H2;
      S_RND_H2:   state_next = S_MUL_WIN;
      S_MUL_WIN:  state_next = S_RND_WIN;
      S_RND_WIN:  state_next = S_MUL_PRE;
      // win is settled here; a zero window skips fhan
      S_MUL_PRE:  state_next = status.win_zero ? S_ACC_ZERO : S_RND_PRE;
      S_ACC_ZERO: state_next = S_MUL_DX;
      S_RND_PRE:  state_next = S_LEAD;
      S_LEAD:     state_next = S_INNER;
      S_INNER:    state_next = S_MUL_RAD;
      S_MUL_RAD:  state_next = S_SQ_INIT;
      S_SQ_INIT:  state_next = S_SQ_RUN;
      S_SQ_RUN:   if (status.sq_last) state_next = S_CURVE;
      S_CURVE:    state_next = S_BLEND;
      S_BLEND:    state_next = S_MUL_P;
      S_MUL_P:    state_next = status.blend_lt_win ? S_DIV_INIT : S_ACC_R;
      S_DIV_INIT: state_next = S_DIV_RUN;
      S_DIV_RUN:  if (status.div_last) state_next = S_ACC_Q;
      S_ACC_Q:    state_next = S_MUL_DX;
      S_ACC_R:    state_next = S_MUL_DX;
      S_MUL_DX:   state_next = S_RND_DX;
      S_RND_DX:   state_next = S_MUL_X;
      S_MUL_X:    state_next = S_RND_X;
      S_RND_X:    state_next = status.angle ? S_WR_INIT : S_POS;
      S_WR_INIT:  state_next = S_WR_RCP;
      S_WR_RCP:   state_next = S_WR_MUL;
      S_WR_MUL:   state_next = S_WR_APPLY;
      S_WR_APPLY: state_next = S_POS;
      S_POS:      state_next = S_EMIT;
      S_EMIT:     if (!status.out_busy) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE:     cmd.op = in_valid ? OP_CAPTURE : OP_NONE;
      S_SORT:     cmd.op = OP_NONE;
      S_LOAD:     cmd.op = OP_LOAD;
      S_ERR:      cmd.op = OP_ERR;
      S_MUL_H0:   cmd.op = OP_MUL_H0;
      S_RND_H0:   cmd.op = OP_RND_H0;
      S_MUL_H2:   cmd.op = OP_MUL_H2;
      S_RND_H2:   cmd.op = OP_RND_H2;
      S_MUL_WIN:  cmd.op = OP_MUL_WIN;
      S_RND_WIN:  cmd.op = OP_RND_WIN;
      S_MUL_PRE:  cmd.op = OP_MUL_PRE;
      S_ACC_ZERO: cmd.op = OP_ACC_ZERO;
      S_RND_PRE:  cmd.op = OP_RND_PRE;
      S_LEAD:     cmd.op = OP_LEAD;
      S_INNER:    cmd.op = OP_INNER;
      S_MUL_RAD:  cmd.op = OP_MUL_RAD;
      S_SQ_INIT:  cmd.op = OP_SQ_INIT;
      S_SQ_RUN:   cmd.op = OP_SQ_STEP;
      S_CURVE:    cmd.op = OP_CURVE;
      S_BLEND:    cmd.op = OP_BLEND;
      S_MUL_P:    cmd.op = OP_MUL_P;
      S_DIV_INIT: cmd.op = OP_DIV_INIT;
      S_DIV_RUN:  cmd.op = OP_DIV_STEP;
      S_ACC_Q:    cmd.op = OP_ACC_Q;
      S_ACC_R:    cmd.op = OP_ACC_R;
      S_MUL_DX:   cmd.op = OP_MUL_DX;
      S_RND_DX:   cmd.op = OP_RND_DX;
      S_MUL_X:    cmd.op = OP_MUL_X;
      S_RND_X:    cmd.op = OP_RND_X;
      S_WR_INIT:  cmd.op = OP_WR_INIT;
      S_WR_RCP:   cmd.op = OP_WR_RCP;
      S_WR_MUL:   cmd.op = OP_WR_MUL;
      S_WR_APPLY: cmd.op = OP_WR_APPLY;
      S_POS:      cmd.op = OP_POS;
      S_EMIT:     cmd.op = OP_EMIT;
      default:    cmd.op = OP_NONE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

FILE: hdl/fhtd_dp.sv
// Datapath of the fhan tracking differentiator: shared multiplier, one
// saturation unit, bit-serial sqrt and divider, state and output register.
// Depends on fhtd_pkg.
module fhtd_dp import fhtd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  in_req_t    in_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_stall,
  output out_res_t   out_data
);

  localparam logic signed [71:0] S32_MAX = 72'sd2147483647;
  localparam logic signed [71:0] S32_MIN = -72'sd2147483648;

  // magnitude product >> sh, rounded half away from zero, then signed
  function automatic logic signed [66:0] rnd(input logic [64:0] p, input int sh,
                                             input logic neg);
    logic [65:0] m;
    m = (66'(p) + (66'd1 << (sh - 1))) >> sh;
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // {clip, value}
  function automatic logic [32:0] sat32(input logic signed [71:0] v);
    if (v > S32_MAX) return {1'b1, 32'h7FFF_FFFF};
    else if (v < S32_MIN) return {1'b1, 32'h8000_0000};
    else return {1'b0, v[31:0]};
  endfunction

  in_req_t            req;
  logic signed [31:0] pos, rate, err, pre, lead, curve, blend, acc;
  logic        [31:0] spd_h, spd_h2, win, inner;
  logic        [64:0] prod;
  logic               neg;
  logic        [63:0] n;
  logic        [35:0] rem;
  logic        [31:0] root;
  logic        [63:0] quo;
  logic        [31:0] dsr;
  logic        [5:0]  cnt;
  logic signed [35:0] posw;
  logic               wr_pos, wr_neg;
  logic               clip;

  logic        [32:0] mul_a;
  logic        [31:0] mul_b;
  logic               mul_neg, mul_en;
  logic signed [71:0] sat_in;
  logic        [32:0] s;
  logic signed [35:0] e0, e0_mag, tgt_adj, err_raw;
  logic        [31:0] rate_mag, acc_mag, lead_mag, blend_mag, half;
  logic signed [34:0] bsum, bhalf;
  logic        [35:0] rem_s, trial;
  logic        [32:0] dt;
  logic signed [35:0] wdvd;
  logic        [34:0] wrem;
  logic               wfix;
  logic signed [35:0] wstep;

  always_comb begin
    rate_mag  = rate[31]  ? 32'(-rate)  : 32'(rate);
    acc_mag   = acc[31]   ? 32'(-acc)   : 32'(acc);
    lead_mag  = lead[31]  ? 32'(-lead)  : 32'(lead);
    blend_mag = blend[31] ? 32'(-blend) : 32'(blend);
    half      = 32'((33'(root) - 33'(win)) >> 1);

    // target error, with the 2*pi shift in angle mode
    e0      = 36'(pos) - 36'(req.target_value);
    e0_mag  = e0[35] ? -e0 : e0;
    tgt_adj = 36'(req.target_value);
    if (cfg.angle_mode && (e0_mag > PI_Q)) begin
      if (req.target_value < 0) tgt_adj = 36'(req.target_value) + TAU_Q;
      else if (req.target_value > 0) tgt_adj = 36'(req.target_value) - TAU_Q;
    end
    err_raw = 36'(pos) - tgt_adj;

    // edge blend halves toward zero
    bsum  = 35'(pre) + 35'(lead) + 35'(curve);
    bhalf = (bsum >>> 1) + $signed({34'd0, bsum[34] & bsum[0]});

    rem_s = {rem[33:0], n[63:62]};
    trial = 36'({root, 2'b01});
    dt    = {rem[31:0], n[63]};

    if (posw > PI_Q) wdvd = posw - PI_Q + TAU_Q - 36'sd1;
    else if (posw < -PI_Q) wdvd = -PI_Q - posw + TAU_Q - 36'sd1;
    else wdvd = '0;

    // turns to remove: reciprocal estimate times 2*pi, plus one more turn if short
    wrem  = 35'(n[33:0]) - 35'(prod[33:0]);
    wfix  = (wrem >= 35'(TAU_Q));
    wstep = $signed(36'(prod[33:0])) + (wfix ? TAU_Q : 36'sd0);
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    mul_en  = 1'b1;
    unique case (cmd.op)
      OP_MUL_H0:  begin mul_a = 33'(cfg.filter_factor); mul_b = 32'(cfg.step_time); end
      OP_MUL_H2:  begin mul_a = 33'(spd_h); mul_b = spd_h; end
      OP_MUL_WIN: begin mul_a = 33'(cfg.track_speed); mul_b = spd_h2; end
      OP_MUL_PRE: begin mul_a = 33'(spd_h); mul_b = rate_mag; mul_neg = rate[31]; end
      OP_MUL_RAD: begin mul_a = 33'(win); mul_b = inner; end
      OP_MUL_P:   begin mul_a = 33'(cfg.track_speed); mul_b = blend_mag; end
      OP_MUL_DX:  begin mul_a = 33'(cfg.step_time); mul_b = acc_mag; mul_neg = acc[31]; end
      OP_MUL_X:   begin mul_a = 33'(cfg.step_time); mul_b = rate_mag; mul_neg = rate[31]; end
      OP_WR_RCP:  begin mul_a = n[32:0]; mul_b = TAU_RCP; end
      OP_WR_MUL:  begin mul_a = 33'(prod >> TAU_RCP_SH); mul_b = 32'(TAU_Q); end
      default:    mul_en = 1'b0;
    endcase
  end

  always_comb begin
    sat_in = '0;
    unique case (cmd.op)
      OP_ERR:     sat_in = 72'(err_raw);
      OP_RND_H0:  sat_in = 72'(rnd(prod, 32 - FRAC_BITS, 1'b0));
      OP_RND_H2,
      OP_RND_WIN,
      OP_RND_PRE: sat_in = 72'(rnd(prod, FRAC_BITS, neg));
      OP_LEAD:    sat_in = 72'(err) + 72'(pre);
      OP_INNER:   sat_in = $signed(72'(win) + (72'(lead_mag) << 3));
      OP_CURVE: begin
        if (lead > 0) sat_in = 72'(pre) + $signed(72'(half));
        else if (lead < 0) sat_in = 72'(pre) - $signed(72'(half));
        else sat_in = 72'(pre);
      end
      OP_BLEND: begin
        if (lead_mag < win) sat_in = 72'(pre) + 72'(lead);
        else if (lead_mag == win) sat_in = 72'(bhalf);
        else sat_in = 72'(curve);
      end
      OP_ACC_Q:   sat_in = blend[31] ? $signed(72'(quo)) : -$signed(72'(quo));
      OP_ACC_R: begin
        if (!blend[31] && (blend != 0)) sat_in = -$signed(72'(cfg.track_speed));
        else sat_in = $signed(72'(cfg.track_speed));
      end
      OP_RND_DX:  sat_in = 72'(rate) + 72'(rnd(prod, 24, neg));
      OP_POS:     sat_in = 72'(posw);
      default:    sat_in = '0;
    endcase
    s = sat32(sat_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
      rate      <= '0;
    end else begin
      if (mul_en) begin
        prod <= 65'(mul_a) * 65'(mul_b);
        neg  <= mul_neg;
      end
      unique case (cmd.op)
        OP_CAPTURE: req <= in_data;
        OP_LOAD: begin
          pos  <= req.position_value;
          acc  <= '0;
          clip <= 1'b0;
        end
        OP_ERR:      begin err    <= s[31:0]; clip <= s[32]; end
        OP_RND_H0:   begin spd_h  <= s[31:0]; clip <= clip | s[32]; end
        OP_RND_H2:   begin spd_h2 <= s[31:0]; clip <= clip | s[32]; end
        OP_RND_WIN:  begin win    <= s[31:0]; clip <= clip | s[32]; end
        OP_RND_PRE:  begin pre    <= s[31:0]; clip <= clip | s[32]; end
        OP_LEAD:     begin lead   <= s[31:0]; clip <= clip | s[32]; end
        OP_INNER:    begin inner  <= s[31:0]; clip <= clip | s[32]; end
        OP_CURVE:    begin curve  <= s[31:0]; clip <= clip | s[32]; end
        OP_BLEND:    begin blend  <= s[31:0]; clip <= clip | s[32]; end
        OP_ACC_Q,
        OP_ACC_R:    begin acc    <= s[31:0]; clip <= clip | s[32]; end
        OP_RND_DX:   begin rate   <= s[31:0]; clip <= clip | s[32]; end
        OP_POS:      begin pos    <= s[31:0]; clip <= clip | s[32]; end
        OP_ACC_ZERO: acc <= '0;
        OP_SQ_INIT: begin
          n    <= prod[63:0];
          root <= '0;
          rem  <= '0;
          cnt  <= '0;
        end
        OP_SQ_STEP: begin
          if (rem_s >= trial) begin
            rem  <= rem_s - trial;
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= rem_s;
            root <= {root[30:0], 1'b0};
          end
          n   <= n << 2;
          cnt <= cnt + 6'd1;
        end
        OP_DIV_INIT: begin
          n   <= prod[63:0] + 64'(win >> 1);
          dsr <= win;
          rem <= '0;
          quo <= '0;
          cnt <= '0;
        end
        OP_DIV_STEP: begin
          if (dt >= 33'(dsr)) begin
            rem <= 36'(dt - 33'(dsr));
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= 36'(dt);
            quo <= {quo[62:0], 1'b0};
          end
          n   <= n << 1;
          cnt <= cnt + 6'd1;
        end
        OP_RND_X: posw <= 36'(pos) + 36'(rnd(prod, 24, neg));
        OP_WR_INIT: begin
          wr_pos <= (posw > PI_Q);
          wr_neg <= (posw < -PI_Q);
          n      <= 64'($unsigned(wdvd));
        end
        OP_WR_APPLY: begin
          if (wr_pos) posw <= posw - wstep;
          else if (wr_neg) posw <= posw + wstep;
        end
        default: ;
      endcase
      if ((cmd.op == OP_EMIT) && !status.out_busy) begin
        out_data.rate_estimate    <= rate;
        out_data.tracked_position <= pos;
        out_data.accel_command    <= acc;
        out_data.saturated        <= clip;
        out_valid                 <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.is_load      = req.req_type;
  assign status.win_zero     = (win == '0);
  assign status.blend_lt_win = (blend_mag < win);
  assign status.sq_last      = (cnt == 6'd31);
  assign status.div_last     = (cnt == 6'd63);
  assign status.out_busy     = out_valid && out_stall;
  assign status.angle        = cfg.angle_mode;

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV_STEP) |-> (dsr != '0))
    else $error("divide step with zero divisor");

  a_load_clean: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD) |=> ((acc == '0) && !clip))
    else $error("load request left accel or clip set");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_CURVE) |-> (root >= win))
    else $error("sqrt below window");

  a_wrap_range: assert property (@(posedge clk) disable iff (rst)
    ((cmd.op == OP_POS) && cfg.angle_mode) |-> ((posw <= PI_Q) && (posw >= -PI_Q)))
    else $error("wrapped position outside +/-pi");

endmodule

FILE: hdl/fhan_tracking_differentiator_top.sv
// Paths per request: a load request, or a track request that skips fhan on a zero
// window, saturates fhan at +/-r, or takes the divide path (32-step sqrt and
// 64-step divide on the shared datapath); angle mode adds the wrap.
// One request in flight; the next is accepted in the cycle after the result register
// loads, even while that result waits on a stall.
// Synchronous reset: position and rate cleared, registers to defaults. Uses fhtd_pkg.
module fhan_tracking_differentiator_top import fhtd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_res_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.track_speed   <= 32'd6553600;
      cfg.step_time     <= 24'd16777;
      cfg.filter_factor <= 16'd256;
      cfg.angle_mode    <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_TRACK_SPEED:   cfg.track_speed   <= pwdata;
        REG_STEP_TIME:     cfg.step_time     <= pwdata[23:0];
        REG_FILTER_FACTOR: cfg.filter_factor <= pwdata[15:0];
        REG_ANGLE_MODE:    cfg.angle_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TRACK_SPEED:   prdata = cfg.track_speed;
      REG_STEP_TIME:     prdata = 32'(cfg.step_time);
      REG_FILTER_FACTOR: prdata = 32'(cfg.filter_factor);
      REG_ANGLE_MODE:    prdata = 32'(cfg.angle_mode);
      default:           prdata = '0;
    endcase
  end

  fhtd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fhtd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
